@@ sv/cls_pkg.sv @@
// Shared types and constants for the compacting list store.
// Item structs, status/mode codes, sequencer states and memory port bundles.
// No dependencies.
`timescale 1ns / 1ps

package cls_pkg;

	// Store geometry
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int DATA_W = 32;

	// Request operation codes
	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_DUMP   = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_REMOVED   = 3'd1,
		ST_BAD_INDEX = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_ELEMENT   = 3'd5
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0]  value;
		logic        [ADDR_W-1:0]  index;
	} req_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  element;
		logic        [ADDR_W-1:0]  position;
		logic                      last;
	} rsp_item_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_DEL,
		S_DUMP
	} state_t;

	// Memory port bundles
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

endpackage

@@ sv/compacting_list_store_core.sv @@
// Top level of the compacting list store: sequencer plus entry memory.
// Depends on cls_pkg, cls_seq and cls_mem.
//
// Usage:
//   Request channel (req_valid/req_ready/req) takes one item: append a value,
//   delete at an index, or dump the list. Response channel
//   (rsp_valid/rsp_ready/rsp) returns status items; a dump returns one item
//   per held entry, in order, with last set on the final one.
//   Append, bad-index delete, full and empty dump pass their result from the
//   result register through the S_RESP state to the output register. A valid
//   delete shifts the entries above its index down, one entry per cycle through
//   the single memory read and write port. A dump streams one entry per cycle
//   from its memory read while the receiver takes them.
//   Only one item is worked on at a time; req_ready is high only while the
//   sequencer is idle, and a finished result may still wait in the output
//   register while the next item is taken.
//   When the receiver stalls, the result register and an in-flight dump read
//   hold their contents and the next result waits; a delete shift runs on.
//   Reset empties the list (count zero); entry contents are not cleared and
//   are only read after being written.
`timescale 1ns / 1ps

module compacting_list_store_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  cls_pkg::req_item_t    req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output cls_pkg::rsp_item_t    rsp
);

	cls_pkg::mem_wr_t             wr;
	cls_pkg::mem_rd_t             rd;
	logic [cls_pkg::DATA_W-1:0]   rdata;

	// Sequencer and count
	cls_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.wr        (wr),
		.rd        (rd),
		.rdata     (rdata)
	);

	// Entry storage
	cls_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

endmodule

@@ sv/cls_mem.sv @@
// Entry store: DEPTH words, one write port and one registered read port.
// Depends on cls_pkg for widths and port bundles.
`timescale 1ns / 1ps

module cls_mem (
	input  logic                          clk,
	input  cls_pkg::mem_wr_t              wr,
	input  cls_pkg::mem_rd_t              rd,
	output logic [cls_pkg::DATA_W-1:0]    rdata
);

	logic [cls_pkg::DATA_W-1:0] mem_q [cls_pkg::DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd.re) begin
			rdata <= mem_q[rd.addr];
		end
	end

endmodule

@@ sv/cls_seq.sv @@
// Sequencer for the list store: decodes items, runs the delete shift and dump
// readout one entry per cycle (dump when not stalled), holds count and result regs.
// Depends on cls_pkg; drives the cls_mem ports.
`timescale 1ns / 1ps

module cls_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cls_pkg::req_item_t            req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cls_pkg::rsp_item_t            rsp,
	output cls_pkg::mem_wr_t              wr,
	output cls_pkg::mem_rd_t              rd,
	input  logic [cls_pkg::DATA_W-1:0]    rdata
);

	cls_pkg::state_t                 state_q, state_d;
	logic [cls_pkg::CNT_W-1:0]       count_q, count_d;
	logic [cls_pkg::CNT_W-1:0]       ptr_q, ptr_d;
	logic                            rd_vld_s1, rd_vld_d;
	logic [cls_pkg::ADDR_W-1:0]      wa_s1, wa_d;
	logic [cls_pkg::ADDR_W-1:0]      pos_s1, pos_d;
	cls_pkg::rsp_item_t              resp_q, resp_d;
	cls_pkg::rsp_item_t              out_q, out_d;
	logic                            out_vld_q, out_vld_d;
	logic                            out_free;
	logic                            issue;
	logic                            ptr_lt_cnt;

	assign rsp       = out_q;
	assign rsp_valid = out_vld_q;
	assign out_free  = !out_vld_q || rsp_ready;
	assign ptr_lt_cnt = (ptr_q < count_q);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cls_pkg::S_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_vld_s1 <= rd_vld_d;
			out_vld_q <= out_vld_d;
		end
	end

	// Payload and pointer registers
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		wa_s1  <= wa_d;
		pos_s1 <= pos_d;
		resp_q <= resp_d;
		out_q  <= out_d;
	end

	// Next state, memory control and results
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		rd_vld_d  = rd_vld_s1;
		wa_d      = wa_s1;
		pos_d     = pos_s1;
		resp_d    = resp_q;
		out_d     = out_q;
		out_vld_d = out_vld_q && !rsp_ready;
		wr        = '0;
		rd        = '0;
		req_ready = 1'b0;
		issue     = 1'b0;

		unique case (state_q)
			cls_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					resp_d = '0;
					resp_d.last = 1'b1;
					unique case (req.mode)
						cls_pkg::MODE_APPEND: begin
							if (count_q == cls_pkg::CNT_W'(cls_pkg::DEPTH)) begin
								resp_d.status = cls_pkg::ST_FULL;
							end else begin
								wr.we   = 1'b1;
								wr.addr = count_q[cls_pkg::ADDR_W-1:0];
								wr.data = req.value;
								count_d = count_q + 1'b1;
								resp_d.status = cls_pkg::ST_ADDED;
							end
							state_d = cls_pkg::S_RESP;
						end
						cls_pkg::MODE_DELETE: begin
							if ({1'b0, req.index} >= count_q) begin
								resp_d.status = cls_pkg::ST_BAD_INDEX;
								state_d = cls_pkg::S_RESP;
							end else begin
								ptr_d    = {1'b0, req.index} + 1'b1;
								rd_vld_d = 1'b0;
								state_d  = cls_pkg::S_DEL;
							end
						end
						cls_pkg::MODE_DUMP: begin
							if (count_q == '0) begin
								resp_d.status = cls_pkg::ST_EMPTY;
								state_d = cls_pkg::S_RESP;
							end else begin
								ptr_d    = '0;
								rd_vld_d = 1'b0;
								state_d  = cls_pkg::S_DUMP;
							end
						end
						default: begin
							// unused code: dropped, no result
						end
					endcase
				end
			end

			cls_pkg::S_RESP: begin
				if (out_free) begin
					out_d     = resp_q;
					out_vld_d = 1'b1;
					state_d   = cls_pkg::S_IDLE;
				end
			end

			// Shift down: read entry p, write it to p-1 next cycle
			cls_pkg::S_DEL: begin
				if (rd_vld_s1) begin
					wr.we   = 1'b1;
					wr.addr = wa_s1;
					wr.data = rdata;
				end
				if (ptr_lt_cnt) begin
					rd.re    = 1'b1;
					rd.addr  = ptr_q[cls_pkg::ADDR_W-1:0];
					wa_d     = ptr_q[cls_pkg::ADDR_W-1:0] - 1'b1;
					ptr_d    = ptr_q + 1'b1;
					rd_vld_d = 1'b1;
				end else begin
					rd_vld_d = 1'b0;
					if (!rd_vld_s1) begin
						count_d = count_q - 1'b1;
						resp_d  = '0;
						resp_d.status = cls_pkg::ST_REMOVED;
						resp_d.last   = 1'b1;
						state_d = cls_pkg::S_RESP;
					end
				end
			end

			// Readout: one entry in flight behind the result register
			cls_pkg::S_DUMP: begin
				if (rd_vld_s1 && out_free) begin
					out_d.status   = cls_pkg::ST_ELEMENT;
					out_d.element  = rdata;
					out_d.position = pos_s1;
					out_d.last     = (({1'b0, pos_s1} + 1'b1) == count_q);
					out_vld_d      = 1'b1;
				end
				issue = ptr_lt_cnt && (!rd_vld_s1 || out_free);
				if (issue) begin
					rd.re = 1'b1;
					rd.addr = ptr_q[cls_pkg::ADDR_W-1:0];
					pos_d = ptr_q[cls_pkg::ADDR_W-1:0];
					ptr_d = ptr_q + 1'b1;
				end
				rd_vld_d = issue || (rd_vld_s1 && !out_free);
				if (!ptr_lt_cnt && !rd_vld_s1) begin
					state_d = cls_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = cls_pkg::S_IDLE;
			end
		endcase
	end

endmodule
